@@ rtl/rat_pkg.sv @@
package rat_pkg;

  // Table depth default
  localparam int unsigned MaxProcesses = 16;

  // Field widths fixed by the interface
  localparam int unsigned IdW      = 16;
  localparam int unsigned QtyW     = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIndexW = 1;

  // Register reset values
  localparam logic [QtyW-1:0] CpuCapacityRst    = 32'd1000;
  localparam logic [QtyW-1:0] MemoryCapacityRst = 32'd1024;

  // Operation codes
  typedef enum logic {
    OP_ASSIGN  = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_ASSIGNED     = 3'd0,
    ST_INSUFFICIENT = 3'd1,
    ST_TABLE_FULL   = 3'd2,
    ST_RELEASED     = 3'd3,
    ST_NOT_FOUND    = 3'd4
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_CPU_CAPACITY    = 1'b0,
    REG_MEMORY_CAPACITY = 1'b1
  } reg_index_e;

endpackage

@@ rtl/resource_admission_table.sv @@
// Resource admission table: admits or releases processes on one compute node.
//
// Input channel: in_valid_i/in_stall_o with operation_i, process_id_i,
// cpu_need_i and memory_need_i. A word is taken when valid is high and stall
// is low. Output channel: out_valid_o/out_stall_i carries one result word per
// input word: status, resources in use, free memory, table fill, running id.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is the compute capacity, index 1 the memory capacity. Write only
// while no word is in flight.
//
// Operation: one word at a time through a single shared 33-bit add/subtract
// unit and a one-port-read table memory. An assign forms the compute sum,
// then the memory sum, then goes to the done state; a full-table refusal or a
// release on an empty table goes to the done state at once. A release reads
// and compares each entry up to the match, returns compute then memory, and
// moves each entry behind it up one place; a miss stops after the last entry.
// The next word is accepted the cycle after the result is loaded in the output
// register, so a stalled receiver holds at most one result while the next word works.
// Reset clears usage, fill count and running process and restores the
// default capacities; the table contents need no clearing.
module resource_admission_table #(
  parameter int unsigned MAX_PROCESSES = rat_pkg::MaxProcesses,
  localparam int unsigned CntW = $clog2(MAX_PROCESSES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rat_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [rat_pkg::QtyW-1:0]     cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [rat_pkg::IdW-1:0]      process_id_i,
  input  logic [rat_pkg::QtyW-1:0]     cpu_need_i,
  input  logic [rat_pkg::QtyW-1:0]     memory_need_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rat_pkg::StatusW-1:0]  status_o,
  output logic [rat_pkg::QtyW-1:0]     used_cpu_o,
  output logic [rat_pkg::QtyW-1:0]     used_memory_o,
  output logic [rat_pkg::QtyW-1:0]     free_memory_o,
  output logic [CntW-1:0]              entries_held_o,
  output logic                         running_valid_o,
  output logic [rat_pkg::IdW-1:0]      running_id_o
);

  localparam int unsigned IdxW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned QtyW = rat_pkg::QtyW;
  localparam int unsigned IdW  = rat_pkg::IdW;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [QtyW-1:0] cpu;
    logic [QtyW-1:0] mem;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_CPU,
    S_CHK_MEM,
    S_RD,
    S_CMP,
    S_SUB_CPU,
    S_SUB_MEM,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [QtyW-1:0]           cpu_cap_q, mem_cap_q;
  logic [QtyW-1:0]           cpu_used_q, cpu_used_d;
  logic [QtyW-1:0]           mem_used_q, mem_used_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [IdW-1:0]            cur_id_q, cur_id_d;
  logic                      cur_valid_q, cur_valid_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [QtyW:0]             new_cpu_q, new_cpu_d;
  rat_pkg::status_e          status_q, status_d;

  // latched input word
  logic [IdW-1:0]            id_q;
  logic [QtyW-1:0]           cneed_q, mneed_q;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [rat_pkg::StatusW-1:0] out_status_q;
  logic [QtyW-1:0]           out_cpu_q, out_mem_q, out_free_q;
  logic [CntW-1:0]           out_count_q;
  logic                      out_run_valid_q;
  logic [IdW-1:0]            out_run_id_q;

  // table memory
  entry_t                    table_mem [MAX_PROCESSES];
  entry_t                    rd_data_q;
  logic                      rd_en, wr_en;
  logic [IdxW-1:0]           rd_addr, wr_addr;
  entry_t                    wr_data;

  // shared add/subtract unit
  logic [QtyW-1:0]           alu_a, alu_b;
  logic                      alu_sub;
  logic [QtyW:0]             alu_res;

  logic                      in_take, out_free_slot, load_out;
  logic [CntW:0]             idx_ext, count_ext;

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

  assign in_take       = in_valid_i && !in_stall_o;
  assign out_free_slot = !out_valid_q || !out_stall_i;
  assign load_out      = (state_q == S_DONE) && out_free_slot;
  assign idx_ext       = {{(CntW + 1 - IdxW){1'b0}}, idx_q};
  assign count_ext     = {1'b0, count_q};

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    cpu_used_d  = cpu_used_q;
    mem_used_d  = mem_used_q;
    count_d     = count_q;
    cur_id_d    = cur_id_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    new_cpu_d   = new_cpu_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    alu_a       = cpu_used_q;
    alu_b       = cneed_q;
    alu_sub     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = rd_data_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          idx_d = '0;
          if (operation_i == rat_pkg::OP_ASSIGN) begin
            if (count_q >= CntW'(MAX_PROCESSES)) begin
              status_d = rat_pkg::ST_TABLE_FULL;
              state_d  = S_DONE;
            end else begin
              state_d = S_CHK_CPU;
            end
          end else if (count_q == '0) begin
            status_d = rat_pkg::ST_NOT_FOUND;
            state_d  = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      // form the compute sum
      S_CHK_CPU: begin
        new_cpu_d = alu_res;
        state_d   = S_CHK_MEM;
      end
      // form the memory sum and commit if both fit
      S_CHK_MEM: begin
        alu_a   = mem_used_q;
        alu_b   = mneed_q;
        state_d = S_DONE;
        if (new_cpu_q > {1'b0, cpu_cap_q} || alu_res > {1'b0, mem_cap_q}) begin
          status_d = rat_pkg::ST_INSUFFICIENT;
        end else begin
          status_d    = rat_pkg::ST_ASSIGNED;
          cpu_used_d  = new_cpu_q[QtyW-1:0];
          mem_used_d  = alu_res[QtyW-1:0];
          wr_en       = 1'b1;
          wr_addr     = count_q[IdxW-1:0];
          wr_data     = '{id: id_q, cpu: cneed_q, mem: mneed_q};
          count_d     = count_q + 1'b1;
          cur_id_d    = id_q;
          cur_valid_d = 1'b1;
        end
      end
      // fetch entry under scan
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_CMP;
      end
      // match or advance
      S_CMP: begin
        if (rd_data_q.id == id_q) begin
          state_d = S_SUB_CPU;
        end else if (idx_ext + 1'b1 >= count_ext) begin
          status_d = rat_pkg::ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      // give back compute
      S_SUB_CPU: begin
        alu_sub    = 1'b1;
        alu_b      = rd_data_q.cpu;
        cpu_used_d = alu_res[QtyW-1:0];
        state_d    = S_SUB_MEM;
      end
      // give back memory, drop running process, start closing the gap
      S_SUB_MEM: begin
        alu_sub    = 1'b1;
        alu_a      = mem_used_q;
        alu_b      = rd_data_q.mem;
        mem_used_d = alu_res[QtyW-1:0];
        if (cur_valid_q && cur_id_q == id_q) begin
          cur_valid_d = 1'b0;
          cur_id_d    = '0;
        end
        status_d = rat_pkg::ST_RELEASED;
        if (idx_ext + 1'b1 < count_ext) begin
          state_d = S_SH_RD;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end
      // fetch the next entry down
      S_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = IdxW'(idx_ext + 1'b1);
        state_d = S_SH_WR;
      end
      // move it up one place
      S_SH_WR: begin
        wr_en = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_ext + 2'd2 < count_ext) begin
          state_d = S_SH_RD;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end
      // free memory, then hand the word to the output register
      S_DONE: begin
        alu_sub = 1'b1;
        alu_a   = mem_cap_q;
        alu_b   = mem_used_q;
        if (out_free_slot) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpu_cap_q   <= rat_pkg::CpuCapacityRst;
      mem_cap_q   <= rat_pkg::MemoryCapacityRst;
      cpu_used_q  <= '0;
      mem_used_q  <= '0;
      count_q     <= '0;
      cur_id_q    <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cpu_used_q  <= cpu_used_d;
      mem_used_q  <= mem_used_d;
      count_q     <= count_d;
      cur_id_q    <= cur_id_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rat_pkg::REG_CPU_CAPACITY:    cpu_cap_q <= cfg_data_i;
          rat_pkg::REG_MEMORY_CAPACITY: mem_cap_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // working and output payload
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    new_cpu_q <= new_cpu_d;
    status_q  <= status_d;
    if (in_take) begin
      id_q    <= process_id_i;
      cneed_q <= cpu_need_i;
      mneed_q <= memory_need_i;
    end
    if (load_out) begin
      out_status_q    <= status_q;
      out_cpu_q       <= cpu_used_q;
      out_mem_q       <= mem_used_q;
      out_free_q      <= alu_res[QtyW] ? '0 : alu_res[QtyW-1:0];
      out_count_q     <= count_q;
      out_run_valid_q <= cur_valid_q;
      out_run_id_q    <= cur_valid_q ? cur_id_q : '0;
    end
  end

  // table memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= table_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign used_cpu_o      = out_cpu_q;
  assign used_memory_o   = out_mem_q;
  assign free_memory_o   = out_free_q;
  assign entries_held_o  = out_count_q;
  assign running_valid_o = out_run_valid_q;
  assign running_id_o    = out_run_id_q;

endmodule
